// ===== sv/rctn_pkg.sv =====
// rctn_pkg: shared types, codes and saturating helpers for the request cost tracker.
// No dependencies; imported by rctn_front, rctn_back and the top level.
package rctn_pkg;

	localparam logic [1:0] KIND_NORMAL    = 2'd0;
	localparam logic [1:0] KIND_READ_ERR  = 2'd1;
	localparam logic [1:0] KIND_WRITE_ERR = 2'd2;
	localparam logic [1:0] KIND_FAULT     = 2'd3;

	typedef struct packed {
		logic rd_err;
		logic wr_err;
		logic fault;
	} kind_flags_t;

	typedef struct packed {
		logic [31:0] duration_us;
		logic [31:0] request_bytes;
		logic [31:0] response_bytes;
		kind_flags_t flags;
	} item_t;

	function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [31:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {33'b0, b};
		return s[64] ? {64{1'b1}} : s[63:0];
	endfunction

	function automatic logic [31:0] sat_inc32(input logic [31:0] a);
		return (a == {32{1'b1}}) ? a : a + 32'd1;
	endfunction

endpackage

// ===== sv/rctn_front.sv =====
// rctn_front: accepts report words, decodes the completion kind and holds them
// in a two-entry queue for the back end. Depends on rctn_pkg.
module rctn_front
	import rctn_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] duration_us,
	input  logic [31:0] request_bytes,
	input  logic [31:0] response_bytes,
	input  logic [1:0]  completion_kind,
	output logic        q_valid,
	output item_t       q_item,
	input  logic        q_pop
);

	item_t       mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;
	item_t       new_item;
	logic        push;

	always_comb begin
		new_item.duration_us    = duration_us;
		new_item.request_bytes  = request_bytes;
		new_item.response_bytes = response_bytes;
		new_item.flags.rd_err   = (completion_kind == KIND_READ_ERR);
		new_item.flags.wr_err   = (completion_kind == KIND_WRITE_ERR);
		new_item.flags.fault    = (completion_kind == KIND_FAULT);
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count out of range");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_valid)
		else $error("pop from empty queue");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !q_pop) |=> (cnt_q == $past(cnt_q) + 2'd1))
		else $error("queue count did not follow push");

endmodule

// ===== sv/rctn_back.sv =====
// rctn_back: updates totals, peaks, error counters and the sorted top duration list,
// then loads the result word register. Depends on rctn_pkg.
module rctn_back
	import rctn_pkg::*;
#(
	parameter int TOP_ENTRIES = 8
)(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  item_t       q_item,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] requests_done,
	output logic [63:0] time_total_us,
	output logic [63:0] request_bytes_total,
	output logic [63:0] response_bytes_total,
	output logic [31:0] request_bytes_peak,
	output logic [31:0] response_bytes_peak,
	output logic [31:0] read_error_count,
	output logic [31:0] write_error_count,
	output logic [31:0] fault_count,
	output logic [31:0] kept_smallest_us,
	output logic [31:0] kept_largest_us
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CMP  = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]             state_q;
	logic [31:0]            dur_q;
	logic [31:0]            top_q [TOP_ENTRIES];
	logic [31:0]            up [TOP_ENTRIES];
	logic [TOP_ENTRIES-1:0] lt_q;
	logic [TOP_ENTRIES-1:0] lt_next;
	logic                   empty_q;
	logic                   below_q;
	logic [31:0]            req_cnt_q;
	logic [63:0]            dur_sum_q;
	logic [63:0]            rq_sum_q;
	logic [63:0]            rs_sum_q;
	logic [31:0]            rq_max_q;
	logic [31:0]            rs_max_q;
	logic [31:0]            rd_errs_q;
	logic [31:0]            wr_errs_q;
	logic [31:0]            faults_q;
	logic                   out_valid_q;
	logic                   load_out;

	assign q_pop     = (state_q == ST_IDLE) && q_valid;
	assign load_out  = (state_q == ST_OUT) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign lt_next   = {1'b0, lt_q[TOP_ENTRIES-1:1]};

	always_comb begin
		for (int i = 0; i < TOP_ENTRIES - 1; i++) begin
			up[i] = top_q[i+1];
		end
		up[TOP_ENTRIES-1] = top_q[TOP_ENTRIES-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			req_cnt_q   <= '0;
			dur_sum_q   <= '0;
			rq_sum_q    <= '0;
			rs_sum_q    <= '0;
			rq_max_q    <= '0;
			rs_max_q    <= '0;
			rd_errs_q   <= '0;
			wr_errs_q   <= '0;
			faults_q    <= '0;
			lt_q        <= '0;
			empty_q     <= 1'b0;
			below_q     <= 1'b0;
			for (int i = 0; i < TOP_ENTRIES; i++) begin
				top_q[i] <= '0;
			end
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						req_cnt_q <= sat_inc32(req_cnt_q);
						dur_sum_q <= sat_add64(dur_sum_q, q_item.duration_us);
						rq_sum_q  <= sat_add64(rq_sum_q, q_item.request_bytes);
						rs_sum_q  <= sat_add64(rs_sum_q, q_item.response_bytes);
						if (q_item.request_bytes > rq_max_q) begin
							rq_max_q <= q_item.request_bytes;
						end
						if (q_item.response_bytes > rs_max_q) begin
							rs_max_q <= q_item.response_bytes;
						end
						if (q_item.flags.rd_err) begin
							rd_errs_q <= sat_inc32(rd_errs_q);
						end
						if (q_item.flags.wr_err) begin
							wr_errs_q <= sat_inc32(wr_errs_q);
						end
						if (q_item.flags.fault) begin
							faults_q <= sat_inc32(faults_q);
						end
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					for (int i = 0; i < TOP_ENTRIES; i++) begin
						lt_q[i] <= (top_q[i] < dur_q);
					end
					empty_q <= (top_q[TOP_ENTRIES-1] == 32'd0);
					below_q <= (dur_q < top_q[0]);
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (!below_q) begin
						if (empty_q) begin
							top_q[TOP_ENTRIES-1] <= dur_q;
						end else begin
							for (int i = 0; i < TOP_ENTRIES; i++) begin
								if (lt_next[i]) begin
									top_q[i] <= up[i];
								end else if (lt_q[i] || (i == 0)) begin
									top_q[i] <= dur_q;
								end
							end
						end
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (load_out) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			dur_q <= q_item.duration_us;
		end
		if (load_out) begin
			requests_done        <= req_cnt_q;
			time_total_us        <= dur_sum_q;
			request_bytes_total  <= rq_sum_q;
			response_bytes_total <= rs_sum_q;
			request_bytes_peak   <= rq_max_q;
			response_bytes_peak  <= rs_max_q;
			read_error_count     <= rd_errs_q;
			write_error_count    <= wr_errs_q;
			fault_count          <= faults_q;
			kept_smallest_us     <= top_q[0];
			kept_largest_us      <= top_q[TOP_ENTRIES-1];
		end
	end

	// list is kept ascending, so the below-d mask is a run of ones from entry 0
	a_lt_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD) |-> ((lt_next & ~lt_q) == '0))
		else $error("compare mask not a prefix");
	a_list_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |-> (top_q[0] <= top_q[TOP_ENTRIES-1]))
		else $error("top list out of order");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (state_q == ST_CMP))
		else $error("pop outside idle");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> out_valid_q)
		else $error("result word not presented");

endmodule

// ===== sv/request_cost_tracker_top_n_core.sv =====
// request_cost_tracker_top_n_core: top level of the request cost tracker.
// Instantiates rctn_front and rctn_back; depends on rctn_pkg.
//
// Usage:
//   Input channel in_valid/in_ready carries one report word: duration_us,
//   request_bytes, response_bytes and completion_kind. Output channel
//   out_valid/out_ready carries one result word per report: the running
//   totals, peaks, error counters and the smallest and largest kept durations
//   after that report.
//   A two-entry queue in the front end takes words while the back end works.
//   The back end handles each word as pop and totals, compare against all
//   kept entries in parallel, list insert and result load, in that order,
//   and pops the next word from the queue only after the result load.
//   If the receiver stalls, the result word waits in its output register; the
//   back end holds the next finished word and the queue keeps taking input
//   until it is full, then in_ready drops.
//   Reset clears all totals, counters, peaks and the kept list to zero and
//   empties the queue.
module request_cost_tracker_top_n_core
	import rctn_pkg::*;
#(
	parameter int TOP_ENTRIES = 8
)(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] duration_us,
	input  logic [31:0] request_bytes,
	input  logic [31:0] response_bytes,
	input  logic [1:0]  completion_kind,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] requests_done,
	output logic [63:0] time_total_us,
	output logic [63:0] request_bytes_total,
	output logic [63:0] response_bytes_total,
	output logic [31:0] request_bytes_peak,
	output logic [31:0] response_bytes_peak,
	output logic [31:0] read_error_count,
	output logic [31:0] write_error_count,
	output logic [31:0] fault_count,
	output logic [31:0] kept_smallest_us,
	output logic [31:0] kept_largest_us
);

	logic  q_valid;
	logic  q_pop;
	item_t q_item;

	rctn_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.duration_us     (duration_us),
		.request_bytes   (request_bytes),
		.response_bytes  (response_bytes),
		.completion_kind (completion_kind),
		.q_valid         (q_valid),
		.q_item          (q_item),
		.q_pop           (q_pop)
	);

	rctn_back #(
		.TOP_ENTRIES (TOP_ENTRIES)
	) u_back (
		.clk                  (clk),
		.arst_n               (arst_n),
		.q_valid              (q_valid),
		.q_item               (q_item),
		.q_pop                (q_pop),
		.out_valid            (out_valid),
		.out_ready            (out_ready),
		.requests_done        (requests_done),
		.time_total_us        (time_total_us),
		.request_bytes_total  (request_bytes_total),
		.response_bytes_total (response_bytes_total),
		.request_bytes_peak   (request_bytes_peak),
		.response_bytes_peak  (response_bytes_peak),
		.read_error_count     (read_error_count),
		.write_error_count    (write_error_count),
		.fault_count          (fault_count),
		.kept_smallest_us     (kept_smallest_us),
		.kept_largest_us      (kept_largest_us)
	);

endmodule

// ===== tb/tb.sv =====
// tb: self-checking testbench for request_cost_tracker_top_n_core.
// Directed table then random report words, each result checked against a local tracker
// model or a typed expected tally. Depends on rctn_pkg and the core RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rctn_pkg::*;

	localparam int N_KEPT = 8;
	localparam int N_DIR = 17;
	localparam int N_RAND_PHASE = 267;
	localparam int LIMIT = 400000;

	typedef struct packed {
		logic [31:0] dur;
		logic [31:0] rq;
		logic [31:0] rs;
		logic [1:0]  kind;
	} report_t;

	typedef struct packed {
		logic [31:0] done;
		logic [63:0] dur_total;
		logic [63:0] rq_total;
		logic [63:0] rs_total;
		logic [31:0] rq_peak;
		logic [31:0] rs_peak;
		logic [31:0] rd_errs;
		logic [31:0] wr_errs;
		logic [31:0] faults;
		logic [31:0] kept_lo;
		logic [31:0] kept_hi;
	} tally_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] duration_us = '0;
	logic [31:0] request_bytes = '0;
	logic [31:0] response_bytes = '0;
	logic [1:0]  completion_kind = KIND_NORMAL;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] requests_done;
	logic [63:0] time_total_us;
	logic [63:0] request_bytes_total;
	logic [63:0] response_bytes_total;
	logic [31:0] request_bytes_peak;
	logic [31:0] response_bytes_peak;
	logic [31:0] read_error_count;
	logic [31:0] write_error_count;
	logic [31:0] fault_count;
	logic [31:0] kept_smallest_us;
	logic [31:0] kept_largest_us;

	request_cost_tracker_top_n_core #(.TOP_ENTRIES(N_KEPT)) u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.duration_us(duration_us), .request_bytes(request_bytes),
		.response_bytes(response_bytes), .completion_kind(completion_kind),
		.out_valid(out_valid), .out_ready(out_ready),
		.requests_done(requests_done), .time_total_us(time_total_us),
		.request_bytes_total(request_bytes_total),
		.response_bytes_total(response_bytes_total),
		.request_bytes_peak(request_bytes_peak),
		.response_bytes_peak(response_bytes_peak),
		.read_error_count(read_error_count), .write_error_count(write_error_count),
		.fault_count(fault_count), .kept_smallest_us(kept_smallest_us),
		.kept_largest_us(kept_largest_us)
	);

	always #5 clk = ~clk;

	// tracker model state
	logic [31:0] kept_us [N_KEPT];
	logic [31:0] req_cnt = '0;
	logic [63:0] dur_sum = '0;
	logic [63:0] rq_sum = '0;
	logic [63:0] rs_sum = '0;
	logic [31:0] rq_max = '0;
	logic [31:0] rs_max = '0;
	logic [31:0] rd_cnt = '0;
	logic [31:0] wr_cnt = '0;
	logic [31:0] flt_cnt = '0;

	report_t dir_rep [N_DIR];
	tally_t  dir_exp [N_DIR];
	bit      dir_typed [N_DIR];

	tally_t pending_tallies [$];
	logic [31:0] floor_hint = '0;
	int errors = 0;
	int taken = 0;
	int cycles = 0;
	int send_idle = 25;
	int recv_idle = 83;

	initial begin
		for (int k = 0; k < N_KEPT; k++)
			kept_us[k] = '0;
	end

	function automatic logic [63:0] sum_sat(logic [63:0] a, logic [31:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {33'd0, b};
		return s[64] ? {64{1'b1}} : s[63:0];
	endfunction

	function automatic logic [31:0] inc_sat(logic [31:0] a);
		return (a == {32{1'b1}}) ? a : a + 32'd1;
	endfunction

	function automatic tally_t apply_report(report_t r);
		tally_t t;
		int pos;
		bit scanning;
		dur_sum = sum_sat(dur_sum, r.dur);
		req_cnt = inc_sat(req_cnt);
		rq_sum = sum_sat(rq_sum, r.rq);
		rs_sum = sum_sat(rs_sum, r.rs);
		if (r.rq > rq_max)
			rq_max = r.rq;
		if (r.rs > rs_max)
			rs_max = r.rs;
		case (r.kind)
			KIND_READ_ERR:  rd_cnt = inc_sat(rd_cnt);
			KIND_WRITE_ERR: wr_cnt = inc_sat(wr_cnt);
			KIND_FAULT:     flt_cnt = inc_sat(flt_cnt);
			default: ;
		endcase
		if (r.dur >= kept_us[0]) begin
			if (kept_us[N_KEPT-1] == '0) begin
				kept_us[N_KEPT-1] = r.dur;
			end else begin
				pos = 0;
				scanning = 1'b1;
				for (int i = 0; i < N_KEPT; i++) begin
					if (scanning && r.dur <= kept_us[i])
						scanning = 1'b0;
					if (scanning)
						pos = i;
				end
				for (int i = 0; i < pos; i++)
					kept_us[i] = kept_us[i+1];
				kept_us[pos] = r.dur;
			end
		end
		t.done = req_cnt;
		t.dur_total = dur_sum;
		t.rq_total = rq_sum;
		t.rs_total = rs_sum;
		t.rq_peak = rq_max;
		t.rs_peak = rs_max;
		t.rd_errs = rd_cnt;
		t.wr_errs = wr_cnt;
		t.faults = flt_cnt;
		t.kept_lo = kept_us[0];
		t.kept_hi = kept_us[N_KEPT-1];
		return t;
	endfunction

	function automatic void cmp_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endfunction

	function automatic void check_tally(tally_t want, tally_t got);
		cmp_field("requests_done", {32'd0, want.done}, {32'd0, got.done});
		cmp_field("time_total_us", want.dur_total, got.dur_total);
		cmp_field("request_bytes_total", want.rq_total, got.rq_total);
		cmp_field("response_bytes_total", want.rs_total, got.rs_total);
		cmp_field("request_bytes_peak", {32'd0, want.rq_peak}, {32'd0, got.rq_peak});
		cmp_field("response_bytes_peak", {32'd0, want.rs_peak}, {32'd0, got.rs_peak});
		cmp_field("read_error_count", {32'd0, want.rd_errs}, {32'd0, got.rd_errs});
		cmp_field("write_error_count", {32'd0, want.wr_errs}, {32'd0, got.wr_errs});
		cmp_field("fault_count", {32'd0, want.faults}, {32'd0, got.faults});
		cmp_field("kept_smallest_us", {32'd0, want.kept_lo}, {32'd0, got.kept_lo});
		cmp_field("kept_largest_us", {32'd0, want.kept_hi}, {32'd0, got.kept_hi});
	endfunction

	function automatic logic [31:0] pick_bytes();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return {32{1'b1}};
			2: return $urandom_range(0, 4095);
			default: return $urandom();
		endcase
	endfunction

	function automatic report_t random_report();
		report_t r;
		logic [31:0] d;
		case ($urandom_range(0, 9))
			4: d = floor_hint + $urandom_range(1, 1000);
			5: d = floor_hint;
			6: d = (floor_hint > 1000) ? floor_hint - $urandom_range(1, 1000)
				: $urandom_range(0, floor_hint);
			7: d = '0;
			8: d = {32{1'b1}};
			9: d = $urandom_range(0, 65535);
			default: d = $urandom();
		endcase
		r.dur = d;
		r.rq = pick_bytes();
		r.rs = pick_bytes();
		r.kind = 2'($urandom_range(0, 3));
		return r;
	endfunction

	// expects to be entered right after a rising edge; returns at the accepting edge
	task automatic send_report(report_t r);
		if ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
		end
		in_valid <= 1'b1;
		duration_us <= r.dur;
		request_bytes <= r.rq;
		response_bytes <= r.rs;
		completion_kind <= r.kind;
		do @(posedge clk); while (!in_ready);
	endtask

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle);
	end

	always @(posedge clk) begin : mon
		report_t r;
		tally_t want;
		tally_t got;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				r.dur = duration_us;
				r.rq = request_bytes;
				r.rs = response_bytes;
				r.kind = completion_kind;
				want = apply_report(r);
				if (taken < N_DIR && dir_typed[taken])
					want = dir_exp[taken];
				pending_tallies.push_back(want);
				taken++;
				floor_hint <= kept_us[0];
			end
			if (out_valid && out_ready) begin
				got.done = requests_done;
				got.dur_total = time_total_us;
				got.rq_total = request_bytes_total;
				got.rs_total = response_bytes_total;
				got.rq_peak = request_bytes_peak;
				got.rs_peak = response_bytes_peak;
				got.rd_errs = read_error_count;
				got.wr_errs = write_error_count;
				got.faults = fault_count;
				got.kept_lo = kept_smallest_us;
				got.kept_hi = kept_largest_us;
				if (pending_tallies.size() == 0) begin
					$error("result word with nothing pending");
					errors++;
				end else begin
					want = pending_tallies.pop_front();
					check_tally(want, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		// typed rows: after reset, all-ones extremes, zero duration onto a one-entry list
		dir_rep[0] = '{32'd0, 32'd0, 32'd0, KIND_NORMAL};
		dir_exp[0] = '{32'd1, 64'd0, 64'd0, 64'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
			32'd0, 32'd0};
		dir_typed[0] = 1'b1;
		dir_rep[1] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, KIND_FAULT};
		dir_exp[1] = '{32'd2, 64'hFFFF_FFFF, 64'hFFFF_FFFF, 64'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'd0, 32'd0, 32'd1, 32'd0, 32'hFFFF_FFFF};
		dir_typed[1] = 1'b1;
		dir_rep[2] = '{32'd0, 32'd0, 32'd0, KIND_READ_ERR};
		dir_exp[2] = '{32'd3, 64'hFFFF_FFFF, 64'hFFFF_FFFF, 64'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'd1, 32'd0, 32'd1, 32'd0, 32'hFFFF_FFFF};
		dir_typed[2] = 1'b1;
		// fill the list, then below, equal to and between kept values
		dir_rep[3] = '{32'd100, 32'd1, 32'd2, KIND_WRITE_ERR};
		dir_rep[4] = '{32'd200, 32'hAAAA_AAAA, 32'h5555_5555, KIND_NORMAL};
		dir_rep[5] = '{32'd300, 32'h5555_5555, 32'hAAAA_AAAA, KIND_READ_ERR};
		dir_rep[6] = '{32'd400, 32'd0, 32'hFFFF_FFFF, KIND_FAULT};
		dir_rep[7] = '{32'd500, 32'hFFFF_FFFF, 32'd0, KIND_WRITE_ERR};
		dir_rep[8] = '{32'd600, 32'h1234_5678, 32'h9ABC_DEF0, KIND_NORMAL};
		dir_rep[9] = '{32'd700, 32'd1, 32'd1, KIND_NORMAL};
		dir_rep[10] = '{32'd50, 32'd7, 32'd7, KIND_READ_ERR};
		dir_rep[11] = '{32'd100, 32'd0, 32'd0, KIND_NORMAL};
		dir_rep[12] = '{32'd450, 32'd3, 32'd4, KIND_WRITE_ERR};
		dir_rep[13] = '{32'hFFFF_FFFF, 32'd0, 32'd0, KIND_FAULT};
		dir_rep[14] = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, KIND_NORMAL};
		dir_rep[15] = '{32'd1, 32'd0, 32'd0, KIND_NORMAL};
		dir_rep[16] = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, KIND_READ_ERR};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIR; i++)
			send_report(dir_rep[i]);

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin send_idle = 25; recv_idle <= 83; end
				1: begin send_idle = 83; recv_idle <= 25; end
				default: begin send_idle = 0; recv_idle <= 0; end
			endcase
			for (int n = 0; n < N_RAND_PHASE; n++)
				send_report(random_report());
		end
		in_valid <= 1'b0;

		while (pending_tallies.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (errors == 0 && pending_tallies.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
sv/rctn_pkg.sv
sv/rctn_front.sv
sv/rctn_back.sv
sv/request_cost_tracker_top_n_core.sv
tb/tb.sv
